### rtl/quaternion_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// quaternion arithmetic unit assertion macros
// shared checks on the ports and pipeline of the quaternion unit
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define QAU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// quaternion arithmetic unit package
// operation codes, pipeline control struct and width helpers
// ----------------------------------------------------------------------------
package qau_pkg;

   localparam int RES_WIDTH      = 32;
   localparam int NUM_LANES      = 4;
   localparam int DEF_FRAC_BITS  = 14;
   localparam int DEF_IN_WIDTH   = 16;

   // tuser bit positions of the result channel
   localparam int USER_ZERO_NORM = 0;
   localparam int USER_SATURATED = 1;
   localparam int RSP_USER_WIDTH = 2;
   localparam int REQ_USER_WIDTH = 3;

   typedef enum logic [2:0] {
      FUNC_MUL     = 3'd0,
      FUNC_INV_MUL = 3'd1,
      FUNC_INV     = 3'd2,
      FUNC_CONJ    = 3'd3,
      FUNC_DOT     = 3'd4
   } func_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero_norm;
      logic [NUM_LANES-1:0] neg;
      logic [NUM_LANES-1:0] ovf;
   } ctrl_type;

   // exact signed sum of products, or a component scaled up by the fraction
   function automatic int sum_width(int w, int f);
      return (2*w + 2 > w + f + 1) ? 2*w + 2 : w + f + 1;
   endfunction

   function automatic int norm_width(int w);
      return 2*w + 1;
   endfunction

   function automatic int num_width(int w, int f);
      return sum_width(w, f) + f + 2;
   endfunction

   function automatic int den_width(int w, int f);
      return (2*w + 2 > f + 2) ? 2*w + 2 : f + 2;
   endfunction

   function automatic int wide_width(int w, int f);
      return (num_width(w, f) > den_width(w, f) + RES_WIDTH) ?
             num_width(w, f) : den_width(w, f) + RES_WIDTH;
   endfunction

endpackage

### rtl/qau_front.sv
// ----------------------------------------------------------------------------
// quaternion unit front end
// stage 1 forms all component products, stage 2 sums them per operation
// ----------------------------------------------------------------------------
module qau_front #(
   parameter int IN_WIDTH  = qau_pkg::DEF_IN_WIDTH,
   parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    ce,
   input  logic                                    valid_in,
   input  logic [2:0]                              func,
   input  logic [3:0][IN_WIDTH-1:0]                a,
   input  logic [3:0][IN_WIDTH-1:0]                b,
   output logic                                    valid_out,
   output logic [3:0][qau_pkg::sum_width(IN_WIDTH, FRAC_BITS)-1:0] v_out,
   output logic [qau_pkg::norm_width(IN_WIDTH)-1:0] norm_out,
   output logic                                    divide_out,
   output logic                                    zn_out
);

   localparam int PW = 2*IN_WIDTH;
   localparam int MW = qau_pkg::sum_width(IN_WIDTH, FRAC_BITS);
   localparam int NW = qau_pkg::norm_width(IN_WIDTH);

   // stage 1
   logic signed [PW-1:0]       p_in [4][4];
   logic signed [PW-1:0]       p_ff [4][4];
   logic        [PW-1:0]       sq_in [4];
   logic        [PW-1:0]       sq_ff [4];
   logic [3:0][IN_WIDTH-1:0]   a_ff;
   logic [2:0]                 func_ff;
   logic                       valid1_ff;

   // stage 2
   logic [3:0][MW-1:0]         v_in;
   logic [3:0][MW-1:0]         v_ff;
   logic [NW-1:0]              norm_in;
   logic [NW-1:0]              norm_ff;
   logic                       divide_in;
   logic                       divide_ff;
   logic                       zn_in;
   logic                       zn_ff;
   logic                       valid2_ff;

   always_comb begin
      logic signed [PW-1:0] ae [4];
      logic signed [PW-1:0] be [4];
      logic signed [PW-1:0] sq;
      for (int i = 0; i < 4; i++) begin
         ae[i] = PW'($signed(a[i]));
         be[i] = PW'($signed(b[i]));
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            p_in[i][j] = ae[i] * be[j];
         end
         sq = ae[i] * ae[i];
         sq_in[i] = sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (ce) begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               p_ff[i][j] <= p_in[i][j];
            end
            sq_ff[i] <= sq_in[i];
         end
         a_ff      <= a;
         func_ff   <= func;
         v_ff      <= v_in;
         norm_ff   <= norm_in;
         divide_ff <= divide_in;
         zn_ff     <= zn_in;
      end
   end

   always_comb begin
      logic signed [MW-1:0] pe [4][4];
      logic signed [MW-1:0] sa [4];
      logic signed [MW-1:0] ux;
      logic signed [MW-1:0] uy;
      logic signed [MW-1:0] uz;
      logic signed [MW-1:0] uw;
      logic                 conj;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pe[i][j] = MW'(p_ff[i][j]);
         end
         sa[i] = MW'($signed(a_ff[i])) <<< FRAC_BITS;
      end
      conj = (func_ff == qau_pkg::FUNC_INV_MUL);
      ux = pe[0][3] + pe[1][2] - pe[2][1];
      uy = pe[1][3] + pe[2][0] - pe[0][2];
      uz = pe[2][3] + pe[0][1] - pe[1][0];
      uw = pe[0][0] + pe[1][1] + pe[2][2];
      v_in = '0;
      case (func_ff)
         qau_pkg::FUNC_MUL, qau_pkg::FUNC_INV_MUL: begin
            v_in[0] = conj ? pe[3][0] - ux : pe[3][0] + ux;
            v_in[1] = conj ? pe[3][1] - uy : pe[3][1] + uy;
            v_in[2] = conj ? pe[3][2] - uz : pe[3][2] + uz;
            v_in[3] = conj ? pe[3][3] + uw : pe[3][3] - uw;
         end
         qau_pkg::FUNC_INV, qau_pkg::FUNC_CONJ: begin
            v_in[0] = -sa[0];
            v_in[1] = -sa[1];
            v_in[2] = -sa[2];
            v_in[3] = sa[3];
         end
         qau_pkg::FUNC_DOT: begin
            v_in[3] = pe[3][3] + uw;
         end
         default: begin
            v_in = '0;
         end
      endcase
      norm_in = NW'(sq_ff[0]) + NW'(sq_ff[1]) + NW'(sq_ff[2]) + NW'(sq_ff[3]);
      divide_in = (func_ff == qau_pkg::FUNC_INV_MUL) || (func_ff == qau_pkg::FUNC_INV);
      zn_in = divide_in && (norm_in == '0);
   end

   assign valid_out  = valid2_ff;
   assign v_out      = v_ff;
   assign norm_out   = norm_ff;
   assign divide_out = divide_ff;
   assign zn_out     = zn_ff;

endmodule

### rtl/qau_prep.sv
// ----------------------------------------------------------------------------
// quaternion unit divider setup
// stage 3 takes magnitudes and forms dividend and divisor, stage 4 checks
// quotient overflow and loads the first partial remainder
// ----------------------------------------------------------------------------
module qau_prep #(
   parameter int IN_WIDTH  = qau_pkg::DEF_IN_WIDTH,
   parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    ce,
   input  logic                                    valid_in,
   input  logic [3:0][qau_pkg::sum_width(IN_WIDTH, FRAC_BITS)-1:0] v_in,
   input  logic [qau_pkg::norm_width(IN_WIDTH)-1:0] norm_in,
   input  logic                                    divide_in,
   input  logic                                    zn_in,
   output qau_pkg::ctrl_type                       ctrl_out,
   output logic [3:0][qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] r_out,
   output logic [3:0][qau_pkg::RES_WIDTH-1:0]      q_out,
   output logic [qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] d_out
);

   localparam int MW = qau_pkg::sum_width(IN_WIDTH, FRAC_BITS);
   localparam int XW = qau_pkg::num_width(IN_WIDTH, FRAC_BITS);
   localparam int DW = qau_pkg::den_width(IN_WIDTH, FRAC_BITS);
   localparam int TW = qau_pkg::wide_width(IN_WIDTH, FRAC_BITS);
   localparam int QW = qau_pkg::RES_WIDTH;

   logic [3:0][XW-1:0] x_in;
   logic [3:0][XW-1:0] x_ff;
   logic [DW-1:0]      d_in;
   logic [DW-1:0]      d3_ff;
   logic [3:0]         neg_in;
   logic [3:0]         neg_ff;
   logic               zn3_ff;
   logic               valid3_ff;

   qau_pkg::ctrl_type  ctrl_in;
   qau_pkg::ctrl_type  ctrl_ff;
   logic [3:0][DW-1:0] r_in;
   logic [3:0][DW-1:0] r_ff;
   logic [3:0][QW-1:0] q_in;
   logic [3:0][QW-1:0] q_ff;
   logic [DW-1:0]      d4_ff;

   always_comb begin
      logic [MW-1:0] m;
      for (int i = 0; i < 4; i++) begin
         neg_in[i] = v_in[i][MW-1];
         m = neg_in[i] ? -v_in[i] : v_in[i];
         x_in[i] = divide_in ? (XW'(m) << (FRAC_BITS + 1)) + XW'(norm_in)
                             : (XW'(m) << 1) + (XW'(1) << FRAC_BITS);
      end
      d_in = divide_in ? DW'(norm_in) << 1 : DW'(1) << (FRAC_BITS + 1);
   end

   always_comb begin
      logic [TW-1:0] hi;
      ctrl_in.valid     = valid3_ff;
      ctrl_in.zero_norm = zn3_ff;
      ctrl_in.neg       = neg_ff;
      for (int i = 0; i < 4; i++) begin
         hi = TW'(x_ff[i]) >> QW;
         ctrl_in.ovf[i] = (hi >= TW'(d3_ff));
         r_in[i] = hi[DW-1:0];
         q_in[i] = x_ff[i][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff     <= 1'b0;
         ctrl_ff.valid <= 1'b0;
      end else if (ce) begin
         valid3_ff     <= valid_in;
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (ce) begin
         x_ff              <= x_in;
         d3_ff             <= d_in;
         neg_ff            <= neg_in;
         zn3_ff            <= zn_in;
         ctrl_ff.zero_norm <= ctrl_in.zero_norm;
         ctrl_ff.neg       <= ctrl_in.neg;
         ctrl_ff.ovf       <= ctrl_in.ovf;
         r_ff              <= r_in;
         q_ff              <= q_in;
         d4_ff             <= d3_ff;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign r_out    = r_ff;
   assign q_out    = q_ff;
   assign d_out    = d4_ff;

endmodule

### rtl/qau_div_stage.sv
// ----------------------------------------------------------------------------
// quaternion unit divider stage
// one restoring division step on all four lanes, quotient bit shifted in
// ----------------------------------------------------------------------------
module qau_div_stage #(
   parameter int IN_WIDTH  = qau_pkg::DEF_IN_WIDTH,
   parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    ce,
   input  qau_pkg::ctrl_type                       ctrl_in,
   input  logic [3:0][qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] r_in,
   input  logic [3:0][qau_pkg::RES_WIDTH-1:0]      q_in,
   input  logic [qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] d_in,
   output qau_pkg::ctrl_type                       ctrl_out,
   output logic [3:0][qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] r_out,
   output logic [3:0][qau_pkg::RES_WIDTH-1:0]      q_out,
   output logic [qau_pkg::den_width(IN_WIDTH, FRAC_BITS)-1:0] d_out
);

   localparam int DW = qau_pkg::den_width(IN_WIDTH, FRAC_BITS);
   localparam int QW = qau_pkg::RES_WIDTH;

   qau_pkg::ctrl_type  ctrl_ff;
   logic [3:0][DW-1:0] r_in_next;
   logic [3:0][DW-1:0] r_ff;
   logic [3:0][QW-1:0] q_in_next;
   logic [3:0][QW-1:0] q_ff;
   logic [DW-1:0]      d_ff;

   always_comb begin
      logic [DW:0] t;
      logic        ge;
      for (int i = 0; i < 4; i++) begin
         t = {r_in[i], q_in[i][QW-1]};
         ge = (t >= {1'b0, d_in});
         r_in_next[i] = ge ? DW'(t - {1'b0, d_in}) : DW'(t);
         q_in_next[i] = {q_in[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (ce) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (ce) begin
         ctrl_ff.zero_norm <= ctrl_in.zero_norm;
         ctrl_ff.neg       <= ctrl_in.neg;
         ctrl_ff.ovf       <= ctrl_in.ovf;
         r_ff              <= r_in_next;
         q_ff              <= q_in_next;
         d_ff              <= d_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign r_out    = r_ff;
   assign q_out    = q_ff;
   assign d_out    = d_ff;

endmodule

### rtl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion arithmetic unit
// Hamilton product, inverse(A)*B, inverse, conjugate and dot product of two
// signed fixed-point quaternions, results rounded and saturated to Q17.14.
//
// req channel: tdata carries A and B, tuser the operation code. rsp channel:
// tdata carries the four result components, tuser the zero-norm and
// saturation flags. An item moves when tvalid and tready are both high.
// From acceptance to rsp_tvalid an item passes the products and sums, the
// divider setup, 32 restoring division steps (one quotient bit per stage
// on all four lanes) and the output register. Every operation runs
// through the same divider; plain rounding divides by a power of two. One
// item is accepted per cycle unless the pipeline is frozen. When rsp_tready
// is low while a result is held, the whole pipeline freezes and req_tready
// drops, so nothing is lost or repeated. Synchronous reset empties the pipeline.
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS = qau_pkg::DEF_FRAC_BITS,
   parameter int IN_WIDTH  = qau_pkg::DEF_IN_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
   input  logic [8*IN_WIDTH-1:0]                 req_tdata,
   // func
   input  logic [qau_pkg::REQ_USER_WIDTH-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // res_x, res_y, res_z, res_w
   output logic [4*qau_pkg::RES_WIDTH-1:0]       rsp_tdata,
   // zero_norm, saturated
   output logic [qau_pkg::RSP_USER_WIDTH-1:0]    rsp_tuser
);

   localparam int MW = qau_pkg::sum_width(IN_WIDTH, FRAC_BITS);
   localparam int NW = qau_pkg::norm_width(IN_WIDTH);
   localparam int DW = qau_pkg::den_width(IN_WIDTH, FRAC_BITS);
   localparam int QW = qau_pkg::RES_WIDTH;
   localparam logic [QW-1:0] RES_MIN = QW'(1) << (QW - 1);
   localparam logic [QW-1:0] RES_MAX = RES_MIN - QW'(1);

   logic                     ce;
   logic [3:0][IN_WIDTH-1:0] a;
   logic [3:0][IN_WIDTH-1:0] b;
   logic                     front_valid;
   logic [3:0][MW-1:0]       front_v;
   logic [NW-1:0]            front_norm;
   logic                     front_divide;
   logic                     front_zn;

   qau_pkg::ctrl_type        ctrl_s [QW+1];
   logic [3:0][DW-1:0]       r_s [QW+1];
   logic [3:0][QW-1:0]       q_s [QW+1];
   logic [DW-1:0]            d_s [QW+1];

   logic                     rsp_valid_ff;
   logic [4*QW-1:0]          rsp_data_in;
   logic [4*QW-1:0]          rsp_data_ff;
   logic [qau_pkg::RSP_USER_WIDTH-1:0] rsp_user_in;
   logic [qau_pkg::RSP_USER_WIDTH-1:0] rsp_user_ff;

   logic                     rsp_zn;
   logic                     rsp_sat;
   logic                     rsp_stall;
   logic [3:0]               rsp_at_limit;

   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a[i] = req_tdata[i*IN_WIDTH +: IN_WIDTH];
         b[i] = req_tdata[(i+4)*IN_WIDTH +: IN_WIDTH];
      end
   end

   qau_front #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .ce         (ce),
      .valid_in   (req_tvalid),
      .func       (req_tuser),
      .a          (a),
      .b          (b),
      .valid_out  (front_valid),
      .v_out      (front_v),
      .norm_out   (front_norm),
      .divide_out (front_divide),
      .zn_out     (front_zn)
   );

   qau_prep #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .valid_in  (front_valid),
      .v_in      (front_v),
      .norm_in   (front_norm),
      .divide_in (front_divide),
      .zn_in     (front_zn),
      .ctrl_out  (ctrl_s[0]),
      .r_out     (r_s[0]),
      .q_out     (q_s[0]),
      .d_out     (d_s[0])
   );

   for (genvar k = 0; k < QW; k++) begin : g_div
      qau_div_stage #(
         .IN_WIDTH  (IN_WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ce       (ce),
         .ctrl_in  (ctrl_s[k]),
         .r_in     (r_s[k]),
         .q_in     (q_s[k]),
         .d_in     (d_s[k]),
         .ctrl_out (ctrl_s[k+1]),
         .r_out    (r_s[k+1]),
         .q_out    (q_s[k+1]),
         .d_out    (d_s[k+1])
      );
   end

   // rounding is done by the divider, here clamp and restore the sign
   always_comb begin
      qau_pkg::ctrl_type c;
      logic [QW-1:0]     lim;
      logic [QW-1:0]     mag;
      logic [3:0]        over;
      c = ctrl_s[QW];
      for (int i = 0; i < 4; i++) begin
         lim = c.neg[i] ? RES_MIN : RES_MAX;
         over[i] = c.ovf[i] || (q_s[QW][i] > lim);
         mag = over[i] ? lim : q_s[QW][i];
         rsp_data_in[i*QW +: QW] = c.zero_norm ? '0 : (c.neg[i] ? -mag : mag);
      end
      rsp_user_in[qau_pkg::USER_ZERO_NORM] = c.zero_norm;
      rsp_user_in[qau_pkg::USER_SATURATED] = !c.zero_norm && (|over);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= ctrl_s[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign rsp_zn    = rsp_tuser[qau_pkg::USER_ZERO_NORM];
   assign rsp_sat   = rsp_tuser[qau_pkg::USER_SATURATED];
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rsp_at_limit[i] = (rsp_tdata[i*QW +: QW] == RES_MAX) ||
                           (rsp_tdata[i*QW +: QW] == RES_MIN);
      end
   end

   `QAU_ASSERT_IMPL(a_flags_exclusive, rsp_tvalid, !(rsp_zn && rsp_sat), "both flags set")
   `QAU_ASSERT_IMPL(a_zero_norm_data, rsp_tvalid && rsp_zn, rsp_tdata == '0, "zero norm data")
   `QAU_ASSERT_IMPL(a_sat_clamped, rsp_tvalid && rsp_sat, |rsp_at_limit, "saturation unclamped")
   `QAU_ASSERT_IMPL(a_stall_blocks_input, rsp_stall, !req_tready, "input open in stall")
   `QAU_ASSERT_NEXT(a_rsp_held, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "rsp moved in stall")

endmodule

### sim/tb_quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion arithmetic unit testbench
// drives directed and random quaternion pairs through the req stream, predicts
// each result with an exact 128-bit model of the arithmetic and compares the
// rsp stream item by item, with random idling on both sides and one long
// receiver hold-off that backs the pipeline up
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit;

   localparam int FB = qau_pkg::DEF_FRAC_BITS;
   localparam int IW = qau_pkg::DEF_IN_WIDTH;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [2:0]    func;
      logic [IW-1:0] bw, bz, by, bx, aw, az, ay, ax;
   } quat_req_type;

   typedef struct packed {
      logic [31:0] rw, rz, ry, rx;
      logic        sat;
      logic        zn;
   } quat_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [8*IW-1:0] req_tdata = '0;
   logic [qau_pkg::REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [4*qau_pkg::RES_WIDTH-1:0] rsp_tdata;
   logic [qau_pkg::RSP_USER_WIDTH-1:0] rsp_tuser;

   quat_req_type pending_items[$];
   quat_rsp_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   bit quiet_phase = 0;
   int send_gap = 0, recv_gap = 0;
   int hold_count = 0;
   bit hold_active = 0;
   bit hold_done = 0;
   int accepted_items = 0;

   quaternion_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // round to nearest, ties away, then clamp; optional exact division by norm
   function automatic logic [31:0] round_sat(logic signed [127:0] v, bit divide,
                                             logic signed [127:0] norm, ref bit sat);
      logic signed [127:0] m, q, lim;
      bit neg;
      neg = v < 0;
      m = neg ? -v : v;
      lim = neg ? 128'sd2147483648 : 128'sd2147483647;
      if (divide) q = ((m <<< (FB + 1)) + norm) / (norm <<< 1);
      else q = ((m <<< 1) + (128'sd1 <<< FB)) / (128'sd1 <<< (FB + 1));
      if (q > lim) begin
         q = lim;
         sat = 1;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic quat_rsp_type quat_compute(quat_req_type r);
      logic signed [127:0] a[4], b[4], l[4], v[4], norm;
      logic [31:0] o[4];
      bit divide, sat;
      quat_rsp_type res;
      a[0] = $signed(r.ax); a[1] = $signed(r.ay); a[2] = $signed(r.az); a[3] = $signed(r.aw);
      b[0] = $signed(r.bx); b[1] = $signed(r.by); b[2] = $signed(r.bz); b[3] = $signed(r.bw);
      norm = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
      divide = 0;
      sat = 0;
      for (int i = 0; i < 4; i++) v[i] = 0;
      l = a;
      if (r.func == qau_pkg::FUNC_INV_MUL) begin
         l[0] = -a[0]; l[1] = -a[1]; l[2] = -a[2];
      end
      case (r.func)
         qau_pkg::FUNC_MUL, qau_pkg::FUNC_INV_MUL: begin
            v[0] = l[3]*b[0] + l[0]*b[3] + l[1]*b[2] - l[2]*b[1];
            v[1] = l[3]*b[1] + l[1]*b[3] + l[2]*b[0] - l[0]*b[2];
            v[2] = l[3]*b[2] + l[2]*b[3] + l[0]*b[1] - l[1]*b[0];
            v[3] = l[3]*b[3] - l[0]*b[0] - l[1]*b[1] - l[2]*b[2];
            divide = r.func == qau_pkg::FUNC_INV_MUL;
         end
         qau_pkg::FUNC_INV, qau_pkg::FUNC_CONJ: begin
            v[0] = -(a[0] <<< FB); v[1] = -(a[1] <<< FB); v[2] = -(a[2] <<< FB);
            v[3] = a[3] <<< FB;
            divide = r.func == qau_pkg::FUNC_INV;
         end
         qau_pkg::FUNC_DOT: v[3] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
         default: ;
      endcase
      res.zn = 0;
      if (divide && norm == 0) begin
         res.zn = 1;
         for (int i = 0; i < 4; i++) o[i] = 0;
      end else begin
         for (int i = 0; i < 4; i++) o[i] = round_sat(v[i], divide, norm, sat);
      end
      res.rx = o[0]; res.ry = o[1]; res.rz = o[2]; res.rw = o[3];
      res.sat = sat;
      return res;
   endfunction

   function automatic logic [IW-1:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h4000;
         4: return 16'hc000;
         5: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(logic [2:0] f, logic [IW-1:0] ax, ay, az, aw, bx, by, bz, bw);
      quat_req_type r;
      r.func = f;
      r.ax = ax; r.ay = ay; r.az = az; r.aw = aw;
      r.bx = bx; r.by = by; r.bz = bz; r.bw = bw;
      pending_items.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(quat_compute(pending_items.pop_front()));
            accepted_items++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 0;
         end else if (!req_tvalid || req_tready) begin
            // head of queue is the next item once the accepted one is popped
            if (pending_items.size() > 0) begin
               if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(1, 5) - 1;
                  req_tvalid <= 0;
               end else begin
                  req_tvalid <= 1;
                  req_tdata <= pending_items[0][8*IW-1:0];
                  req_tuser <= pending_items[0].func;
               end
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // long receiver hold-off once the pipeline has work in it
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_active) begin
            hold_count <= hold_count + 1;
            if (hold_count >= 119) begin
               hold_active <= 0;
               hold_done <= 1;
            end
         end else if (!hold_done && accepted_items >= 60) begin
            hold_active <= 1;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      quat_rsp_type got, want;
      cycles++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.rx = rsp_tdata[31:0]; got.ry = rsp_tdata[63:32];
            got.rz = rsp_tdata[95:64]; got.rw = rsp_tdata[127:96];
            got.zn = rsp_tuser[qau_pkg::USER_ZERO_NORM];
            got.sat = rsp_tuser[qau_pkg::USER_SATURATED];
            if (expected_results.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (got.rx !== want.rx) begin
                  $error("res_x expected %h actual %h", want.rx, got.rx); errors++;
               end
               if (got.ry !== want.ry) begin
                  $error("res_y expected %h actual %h", want.ry, got.ry); errors++;
               end
               if (got.rz !== want.rz) begin
                  $error("res_z expected %h actual %h", want.rz, got.rz); errors++;
               end
               if (got.rw !== want.rw) begin
                  $error("res_w expected %h actual %h", want.rw, got.rw); errors++;
               end
               if (got.zn !== want.zn) begin
                  $error("zero_norm expected %b actual %b", want.zn, got.zn); errors++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated expected %b actual %b", want.sat, got.sat); errors++;
               end
            end
         end
         if (hold_active) begin
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 5) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   initial begin
      logic [2:0] f;
      repeat (3) @(posedge clock);
      reset <= 0;
      add_item(qau_pkg::FUNC_MUL, 16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0);
      add_item(qau_pkg::FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_item(qau_pkg::FUNC_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
               16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_item(qau_pkg::FUNC_INV_MUL, 16'h1234, 16'hfedc, 16'h0042, 16'h4000,
               16'h7fff, 16'h8000, 16'h0001, 16'hffff);
      add_item(qau_pkg::FUNC_INV_MUL, 0, 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      add_item(qau_pkg::FUNC_INV_MUL, 0, 0, 0, 1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      add_item(qau_pkg::FUNC_INV, 0, 0, 0, 0, 16'h1111, 0, 0, 0);
      add_item(qau_pkg::FUNC_INV, 0, 0, 0, 16'h0001, 0, 0, 0, 0);
      add_item(qau_pkg::FUNC_INV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
      add_item(qau_pkg::FUNC_INV, 16'h0001, 16'hffff, 0, 0, 0, 0, 0, 0);
      add_item(qau_pkg::FUNC_CONJ, 16'h8000, 16'h7fff, 16'h0001, 16'h8000, 0, 0, 0, 0);
      add_item(qau_pkg::FUNC_DOT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_item(qau_pkg::FUNC_DOT, 16'h7fff, 16'h0001, 16'hffff, 16'h2000,
               16'h8000, 16'h3fff, 16'h0002, 16'hc001);
      add_item(3'd5, 16'h1234, 16'h5678, 0, 0, 16'h7fff, 0, 0, 0);
      add_item(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 1, 1);
      add_item(3'd7, 16'h8000, 0, 16'h7fff, 0, 0, 0, 0, 0);
      for (int i = 0; i < 450; i++) begin
         f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
         if ($urandom_range(0, 19) == 0)
            add_item(f, 0, 0, 0, 0, rand_comp(), rand_comp(), rand_comp(), rand_comp());
         else
            add_item(f, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      while (pending_items.size() > 0 || expected_results.size() > 0) begin
         @(posedge clock);
         // last stretch of the run goes without idling
         if (pending_items.size() < 50) quiet_phase = 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/qau_pkg.sv
rtl/qau_front.sv
rtl/qau_prep.sv
rtl/qau_div_stage.sv
rtl/quaternion_arithmetic_unit.sv
sim/tb_quaternion_arithmetic_unit.sv
